/* hdl/rscl_pkg.sv */
// Shared types, constants and ring helpers for the ring spin class-list engine.
`timescale 1ns / 1ps
`default_nettype none
package rscl_pkg;

    localparam int RING_SITES  = 1024;
    localparam int CLASS_COUNT = 8;
    localparam int SITE_W      = 10;
    localparam int CLASS_W     = 3;
    localparam int SIZE_W      = 11;
    localparam int POS_W       = 10;
    localparam int ENT_AW      = CLASS_W + POS_W;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_OC_LL,
        ST_OC_L,
        ST_OC_S,
        ST_OC_R,
        ST_OC_RR,
        ST_OC_LAST,
        ST_FLIP,
        ST_RL_BACK,
        ST_RL_LAST,
        ST_RL_MOVE,
        ST_RL_ADD,
        ST_FIN_RD,
        ST_FIN_CAP
    } state_t;

    typedef enum logic [2:0] {
        OA_LL,
        OA_L,
        OA_S,
        OA_R,
        OA_RR
    } occ_sel_t;

    typedef enum logic [1:0] {
        TGT_SITE,
        TGT_LEFT,
        TGT_RIGHT
    } tgt_t;

    typedef struct packed {
        logic     clr_wr;
        logic     accept;
        occ_sel_t occ_sel;
        logic     occ_shift;
        logic     flip;
        logic     back_rd;
        logic     last_rd;
        logic     move_wr;
        logic     add_wr;
        logic     fin_rd;
        logic     fin_cap;
        tgt_t     tgt;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic no_flip;
        logic out_busy;
    } status_t;

    function automatic logic [SITE_W-1:0] left_of(input logic [SITE_W-1:0] s);
        logic [SITE_W-1:0] r;
        if (s == '0) begin
            r = SITE_W'(RING_SITES - 1);
        end else begin
            r = s - 1'b1;
        end
        return r;
    endfunction

    function automatic logic [SITE_W-1:0] right_of(input logic [SITE_W-1:0] s);
        logic [SITE_W-1:0] r;
        if (s == SITE_W'(RING_SITES - 1)) begin
            r = '0;
        end else begin
            r = s + 1'b1;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* hdl/rscl_ctrl.sv */
// Sequencer that steps the datapath through clearing, flips, relists and reads.
`timescale 1ns / 1ps
`default_nettype none
module rscl_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  rscl_pkg::status_t     stat,
    output rscl_pkg::cmd_t        cmd
);

    rscl_pkg::state_t state_reg, state_next;
    rscl_pkg::tgt_t   tgt_reg, tgt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rscl_pkg::ST_CLEAR;
            tgt_reg   <= rscl_pkg::TGT_SITE;
        end else begin
            state_reg <= state_next;
            tgt_reg   <= tgt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        tgt_next   = tgt_reg;
        case (state_reg)
            rscl_pkg::ST_CLEAR: begin
                if (stat.clr_done) state_next = rscl_pkg::ST_IDLE;
            end
            rscl_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = rscl_pkg::ST_OC_LL;
            end
            rscl_pkg::ST_OC_LL:   state_next = rscl_pkg::ST_OC_L;
            rscl_pkg::ST_OC_L:    state_next = rscl_pkg::ST_OC_S;
            rscl_pkg::ST_OC_S:    state_next = rscl_pkg::ST_OC_R;
            rscl_pkg::ST_OC_R:    state_next = rscl_pkg::ST_OC_RR;
            rscl_pkg::ST_OC_RR:   state_next = rscl_pkg::ST_OC_LAST;
            rscl_pkg::ST_OC_LAST: state_next = rscl_pkg::ST_FLIP;
            rscl_pkg::ST_FLIP: begin
                tgt_next = rscl_pkg::TGT_SITE;
                if (stat.no_flip) begin
                    state_next = rscl_pkg::ST_FIN_RD;
                end else begin
                    state_next = rscl_pkg::ST_RL_BACK;
                end
            end
            rscl_pkg::ST_RL_BACK: state_next = rscl_pkg::ST_RL_LAST;
            rscl_pkg::ST_RL_LAST: state_next = rscl_pkg::ST_RL_MOVE;
            rscl_pkg::ST_RL_MOVE: state_next = rscl_pkg::ST_RL_ADD;
            rscl_pkg::ST_RL_ADD: begin
                case (tgt_reg)
                    rscl_pkg::TGT_SITE: begin
                        tgt_next   = rscl_pkg::TGT_LEFT;
                        state_next = rscl_pkg::ST_RL_BACK;
                    end
                    rscl_pkg::TGT_LEFT: begin
                        tgt_next   = rscl_pkg::TGT_RIGHT;
                        state_next = rscl_pkg::ST_RL_BACK;
                    end
                    default: state_next = rscl_pkg::ST_FIN_RD;
                endcase
            end
            rscl_pkg::ST_FIN_RD: state_next = rscl_pkg::ST_FIN_CAP;
            rscl_pkg::ST_FIN_CAP: begin
                if (!stat.out_busy) state_next = rscl_pkg::ST_IDLE;
            end
            default: state_next = rscl_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd           = '0;
        cmd.occ_sel   = rscl_pkg::OA_LL;
        cmd.tgt       = tgt_reg;
        s_tready      = 1'b0;
        case (state_reg)
            rscl_pkg::ST_CLEAR: cmd.clr_wr = 1'b1;
            rscl_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            rscl_pkg::ST_OC_LL: cmd.occ_sel = rscl_pkg::OA_LL;
            rscl_pkg::ST_OC_L: begin
                cmd.occ_sel   = rscl_pkg::OA_L;
                cmd.occ_shift = 1'b1;
            end
            rscl_pkg::ST_OC_S: begin
                cmd.occ_sel   = rscl_pkg::OA_S;
                cmd.occ_shift = 1'b1;
            end
            rscl_pkg::ST_OC_R: begin
                cmd.occ_sel   = rscl_pkg::OA_R;
                cmd.occ_shift = 1'b1;
            end
            rscl_pkg::ST_OC_RR: begin
                cmd.occ_sel   = rscl_pkg::OA_RR;
                cmd.occ_shift = 1'b1;
            end
            rscl_pkg::ST_OC_LAST: cmd.occ_shift = 1'b1;
            rscl_pkg::ST_FLIP:    cmd.flip      = 1'b1;
            rscl_pkg::ST_RL_BACK: cmd.back_rd   = 1'b1;
            rscl_pkg::ST_RL_LAST: cmd.last_rd   = 1'b1;
            rscl_pkg::ST_RL_MOVE: cmd.move_wr   = 1'b1;
            rscl_pkg::ST_RL_ADD:  cmd.add_wr    = 1'b1;
            rscl_pkg::ST_FIN_RD:  cmd.fin_rd    = 1'b1;
            rscl_pkg::ST_FIN_CAP: cmd.fin_cap   = !stat.out_busy;
            default: cmd.clr_wr = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

/* hdl/rscl_datapath.sv */
// Occupancy, back-index and list memories, list sizes and the result register.
`timescale 1ns / 1ps
`default_nettype none
module rscl_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  rscl_pkg::cmd_t                     cmd,
    output rscl_pkg::status_t                  stat,
    input  wire logic                          in_op,
    input  wire logic [rscl_pkg::SITE_W-1:0]   in_site,
    input  wire logic [rscl_pkg::CLASS_W-1:0]  in_list_id,
    input  wire logic [rscl_pkg::POS_W-1:0]    in_position,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [rscl_pkg::CLASS_W-1:0]       out_site_class,
    output logic [rscl_pkg::SIZE_W-1:0]        out_list_size,
    output logic [rscl_pkg::SITE_W-1:0]        out_entry_site,
    output logic                               out_entry_valid
);

    localparam int BACK_W = rscl_pkg::CLASS_W + rscl_pkg::POS_W;

    logic                          occ_mem [rscl_pkg::RING_SITES];
    logic [BACK_W-1:0]             back_mem [rscl_pkg::RING_SITES];
    logic [rscl_pkg::SITE_W-1:0]   ent_mem [rscl_pkg::CLASS_COUNT * rscl_pkg::RING_SITES];
    logic [rscl_pkg::SIZE_W-1:0]   size_reg [rscl_pkg::CLASS_COUNT];

    logic [rscl_pkg::SITE_W-1:0]   clr_cnt_reg;
    logic                          op_reg;
    logic [rscl_pkg::SITE_W-1:0]   site_reg;
    logic [rscl_pkg::CLASS_W-1:0]  lid_reg;
    logic [rscl_pkg::POS_W-1:0]    pos_in_reg;
    logic                          occ_rd_reg;
    logic [4:0]                    occ_sh_reg;
    logic [BACK_W-1:0]             back_rd_reg;
    logic [rscl_pkg::SITE_W-1:0]   ent_rd_reg;
    logic [rscl_pkg::CLASS_W-1:0]  cls_s_reg, cls_l_reg, cls_r_reg;
    logic [rscl_pkg::CLASS_W-1:0]  old_reg;
    logic [rscl_pkg::POS_W-1:0]    pos_reg;
    logic                          rm_ok_reg;
    logic                          fin_ok_reg;
    logic [rscl_pkg::SIZE_W-1:0]   fin_size_reg;
    logic                          m_tvalid_reg;

    logic [rscl_pkg::SITE_W-1:0]   left_s, right_s, occ_addr, tgt_site;
    logic [rscl_pkg::CLASS_W-1:0]  tgt_cls, sz_raddr;
    logic [rscl_pkg::SIZE_W-1:0]   sz_rd;
    logic                          in_ring, flip_en, os;
    logic [rscl_pkg::CLASS_W-1:0]  rd_old;
    logic [rscl_pkg::POS_W-1:0]    rd_pos;
    logic [rscl_pkg::SIZE_W-1:0]   n_minus;

    assign left_s  = rscl_pkg::left_of(site_reg);
    assign right_s = rscl_pkg::right_of(site_reg);
    assign in_ring = 32'(site_reg) < rscl_pkg::RING_SITES;
    assign flip_en = !op_reg && in_ring;
    assign os      = occ_sh_reg[2] ^ flip_en;
    assign rd_old  = back_rd_reg[BACK_W-1 -: rscl_pkg::CLASS_W];
    assign rd_pos  = back_rd_reg[rscl_pkg::POS_W-1:0];
    assign n_minus = sz_rd - 1'b1;

    always_comb begin
        case (cmd.occ_sel)
            rscl_pkg::OA_LL: occ_addr = rscl_pkg::left_of(left_s);
            rscl_pkg::OA_L:  occ_addr = left_s;
            rscl_pkg::OA_S:  occ_addr = site_reg;
            rscl_pkg::OA_R:  occ_addr = right_s;
            rscl_pkg::OA_RR: occ_addr = rscl_pkg::right_of(right_s);
            default:         occ_addr = site_reg;
        endcase
        case (cmd.tgt)
            rscl_pkg::TGT_SITE: begin
                tgt_site = site_reg;
                tgt_cls  = cls_s_reg;
            end
            rscl_pkg::TGT_LEFT: begin
                tgt_site = left_s;
                tgt_cls  = cls_l_reg;
            end
            default: begin
                tgt_site = right_s;
                tgt_cls  = cls_r_reg;
            end
        endcase
        if (cmd.last_rd) begin
            sz_raddr = rd_old;
        end else if (cmd.fin_rd) begin
            sz_raddr = lid_reg;
        end else begin
            sz_raddr = tgt_cls;
        end
    end

    assign sz_rd = size_reg[sz_raddr];

    always_ff @(posedge aclk) begin
        occ_rd_reg <= occ_mem[occ_addr];
        if (cmd.clr_wr) begin
            occ_mem[clr_cnt_reg] <= 1'b0;
        end else if (cmd.flip && flip_en) begin
            occ_mem[site_reg] <= os;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.back_rd) begin
            back_rd_reg <= back_mem[tgt_site];
        end
        if (cmd.clr_wr) begin
            back_mem[clr_cnt_reg] <= {rscl_pkg::CLASS_W'(0), clr_cnt_reg};
        end else if (cmd.move_wr && rm_ok_reg && 32'(ent_rd_reg) < rscl_pkg::RING_SITES) begin
            back_mem[ent_rd_reg] <= {old_reg, pos_reg};
        end else if (cmd.add_wr && 32'(sz_rd) < rscl_pkg::RING_SITES) begin
            back_mem[tgt_site] <= {tgt_cls, sz_rd[rscl_pkg::POS_W-1:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.last_rd) begin
            ent_rd_reg <= ent_mem[{rd_old, n_minus[rscl_pkg::POS_W-1:0]}];
        end else if (cmd.fin_rd) begin
            ent_rd_reg <= ent_mem[{lid_reg, pos_in_reg}];
        end
        if (cmd.clr_wr) begin
            ent_mem[{rscl_pkg::CLASS_W'(0), clr_cnt_reg}] <= clr_cnt_reg;
        end else if (cmd.move_wr && rm_ok_reg) begin
            ent_mem[{old_reg, pos_reg}] <= ent_rd_reg;
        end else if (cmd.add_wr && 32'(sz_rd) < rscl_pkg::RING_SITES) begin
            ent_mem[{tgt_cls, sz_rd[rscl_pkg::POS_W-1:0]}] <= tgt_site;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < rscl_pkg::CLASS_COUNT; i++) begin
                size_reg[i] <= '0;
            end
            size_reg[0]  <= rscl_pkg::SIZE_W'(rscl_pkg::RING_SITES);
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.clr_wr) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.move_wr && rm_ok_reg) begin
                size_reg[old_reg] <= size_reg[old_reg] - 1'b1;
            end else if (cmd.add_wr && 32'(sz_rd) < rscl_pkg::RING_SITES) begin
                size_reg[tgt_cls] <= sz_rd + 1'b1;
            end
            if (cmd.fin_cap) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg     <= in_op;
            site_reg   <= in_site;
            lid_reg    <= in_list_id;
            pos_in_reg <= in_position;
        end
        if (cmd.occ_shift) begin
            occ_sh_reg <= {occ_sh_reg[3:0], occ_rd_reg};
        end
        if (cmd.flip) begin
            cls_s_reg <= {os, occ_sh_reg[1], occ_sh_reg[3]};
            cls_l_reg <= {occ_sh_reg[3], os, occ_sh_reg[4]};
            cls_r_reg <= {occ_sh_reg[1], occ_sh_reg[0], os};
        end
        if (cmd.last_rd) begin
            old_reg   <= rd_old;
            pos_reg   <= rd_pos;
            rm_ok_reg <= (sz_rd != '0) && ({1'b0, rd_pos} < sz_rd);
        end
        if (cmd.fin_rd) begin
            fin_ok_reg   <= ({1'b0, pos_in_reg} < sz_rd)
                            && (32'(pos_in_reg) < rscl_pkg::RING_SITES);
            fin_size_reg <= sz_rd;
        end
        if (cmd.fin_cap) begin
            out_site_class  <= in_ring ? cls_s_reg : '0;
            out_list_size   <= fin_size_reg;
            out_entry_site  <= fin_ok_reg ? ent_rd_reg : '0;
            out_entry_valid <= fin_ok_reg;
        end
    end

    assign m_tvalid      = m_tvalid_reg;
    assign stat.clr_done = (clr_cnt_reg == rscl_pkg::SITE_W'(rscl_pkg::RING_SITES - 1));
    assign stat.no_flip  = !flip_en;
    assign stat.out_busy = m_tvalid_reg && !m_tready;

endmodule
`default_nettype wire

/* hdl/ring_spin_class_list_engine.sv */
// Top level of the ring spin class-list engine: stream ports, sequencer and datapath.
//
// The slave channel takes one transaction per operation: a flip of one ring site
// (tuser low) or a plain read (tuser high). Each accepted transaction produces
// exactly one transaction on the master channel, carrying the class of the
// addressed site after the operation and the size and one entry of the requested
// class list.
// Between acceptance and m_tvalid the block reads the occupancy of the site and
// its four nearest neighbours, makes one class update, for a flip makes three
// remove-and-append moves (site, left and right neighbour), each a back-index
// read, a last-entry read, a move and an append, and then reads the list.
// s_tready returns in the same cycle as m_tvalid rises, so the block takes no new
// operation before the result of the last one is registered.
// After reset the block clears its memories, one site per cycle, with s_tready
// low; then every site is empty and sits on list 0.
// The result is held in an output register. When the receiver stalls, the block
// finishes the operation in hand and waits until the pending result is taken.
`timescale 1ns / 1ps
`default_nettype none
module ring_spin_class_list_engine (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // site[9:0], list_id[12:10], position[22:13], zero
    input  wire logic        s_tuser,   // op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // site_class[2:0], list_size[13:3],
                                        // entry_site[23:14], entry_valid[24], zero
);

    rscl_pkg::cmd_t    cmd;
    rscl_pkg::status_t stat;

    logic [rscl_pkg::CLASS_W-1:0] site_class;
    logic [rscl_pkg::SIZE_W-1:0]  list_size;
    logic [rscl_pkg::SITE_W-1:0]  entry_site;
    logic                         entry_valid;

    rscl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rscl_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .in_op           (s_tuser),
        .in_site         (s_tdata[9:0]),
        .in_list_id      (s_tdata[12:10]),
        .in_position     (s_tdata[22:13]),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .out_site_class  (site_class),
        .out_list_size   (list_size),
        .out_entry_site  (entry_site),
        .out_entry_valid (entry_valid)
    );

    assign m_tdata = {7'd0, entry_valid, entry_site, list_size, site_class};

endmodule
`default_nettype wire

/* sim/ring_spin_class_list_engine_tb.sv */
// Self-checking testbench for the ring spin class-list engine: directed and random flips and reads.
`timescale 1ns / 1ps
module ring_spin_class_list_engine_tb;

    localparam logic OP_FLIP = 1'b0;
    localparam logic OP_READ = 1'b1;
    localparam int LIMIT_CYCLES = 600000;

    typedef struct packed {
        logic        entry_valid;
        logic [9:0]  entry_site;
        logic [10:0] list_size;
        logic [2:0]  site_class;
    } lookup_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    logic        ring_occ [rscl_pkg::RING_SITES];
    int unsigned list_slot [rscl_pkg::CLASS_COUNT][rscl_pkg::RING_SITES];
    int unsigned list_len [rscl_pkg::CLASS_COUNT];
    int unsigned site_list [rscl_pkg::RING_SITES];
    int unsigned site_pos [rscl_pkg::RING_SITES];

    lookup_t     pending_lookups[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    bit          sink_idle = 1'b1;
    bit          long_hold = 1'b0;
    bit          quiet = 1'b0;

    ring_spin_class_list_engine i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic int unsigned ring_left(int unsigned s);
        return (s == 0) ? rscl_pkg::RING_SITES - 1 : s - 1;
    endfunction

    function automatic int unsigned ring_right(int unsigned s);
        return (s == rscl_pkg::RING_SITES - 1) ? 0 : s + 1;
    endfunction

    function automatic int unsigned neighbor_class(int unsigned s);
        return (int'(ring_occ[s]) << 2) | int'(ring_occ[ring_left(s)])
               | (int'(ring_occ[ring_right(s)]) << 1);
    endfunction

    function automatic void move_to_class(int unsigned s);
        int unsigned old_cls;
        int unsigned hole;
        int unsigned cls;
        int unsigned n;
        int unsigned tail;
        old_cls = site_list[s];
        hole = site_pos[s];
        cls = neighbor_class(s);
        n = list_len[old_cls];
        if (n > 0 && hole < n) begin
            tail = list_slot[old_cls][n-1];
            list_slot[old_cls][hole] = tail;
            list_len[old_cls] = n - 1;
            site_pos[tail] = hole;
        end
        n = list_len[cls];
        if (n < rscl_pkg::RING_SITES) begin
            list_slot[cls][n] = s;
            list_len[cls] = n + 1;
            site_list[s] = cls;
            site_pos[s] = n;
        end
    endfunction

    function automatic void clear_ring();
        for (int s = 0; s < rscl_pkg::RING_SITES; s++) begin
            ring_occ[s] = 1'b0;
            list_slot[0][s] = s;
            site_list[s] = 0;
            site_pos[s] = s;
        end
        for (int c = 0; c < rscl_pkg::CLASS_COUNT; c++) list_len[c] = 0;
        list_len[0] = rscl_pkg::RING_SITES;
    endfunction

    function automatic lookup_t apply_op(logic op, int unsigned s, int unsigned lid,
                                         int unsigned pos);
        lookup_t r;
        if (op == OP_FLIP) begin
            ring_occ[s] = ~ring_occ[s];
            move_to_class(s);
            move_to_class(ring_left(s));
            move_to_class(ring_right(s));
        end
        r.site_class = 3'(neighbor_class(s));
        r.list_size = 11'(list_len[lid]);
        if (pos < list_len[lid]) begin
            r.entry_site = 10'(list_slot[lid][pos]);
            r.entry_valid = 1'b1;
        end else begin
            r.entry_site = '0;
            r.entry_valid = 1'b0;
        end
        return r;
    endfunction

    task automatic send_op(logic op, int unsigned s, int unsigned lid, int unsigned pos);
        int unsigned gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {1'b0, pos[9:0], lid[2:0], s[9:0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_lookups.push_back(apply_op(op, s, lid, pos));
    endtask

    task automatic send_random_op(int unsigned flip_pct);
        logic op;
        int unsigned lid;
        int unsigned pos;
        op = ($urandom_range(0, 99) < flip_pct) ? OP_FLIP : OP_READ;
        lid = $urandom_range(0, 7);
        if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, 1023);
        else pos = $urandom_range(0, list_len[lid] + 2);
        if (pos > 1023) pos = 1023;
        send_op(op, $urandom_range(0, 1023), lid, pos);
    endtask

    task automatic test_extremes();
        send_op(OP_READ, 0, 0, 0);
        send_op(OP_READ, 1023, 0, 1023);
        send_op(OP_READ, 5, 7, 1023);
        send_op(OP_FLIP, 0, 4, 0);
        send_op(OP_FLIP, 1023, 0, 1023);
        send_op(OP_FLIP, 1, 5, 0);
        send_op(OP_FLIP, 1022, 6, 0);
        send_op(OP_FLIP, 511, 3, 0);
        send_op(OP_FLIP, 512, 7, 0);
        send_op(OP_FLIP, 513, 7, 1);
        send_op(OP_READ, 512, 7, 2);
        for (int c = 0; c < rscl_pkg::CLASS_COUNT; c++) send_op(OP_READ, c, c, 0);
        send_op(OP_FLIP, 512, 2, 1000);
        send_op(OP_READ, 682, 0, 1020);
    endtask

    task automatic test_dense_cluster();
        for (int i = 0; i < 400; i++) begin
            send_op(OP_FLIP, 100 + $urandom_range(0, 15), $urandom_range(0, 7),
                    $urandom_range(0, 20));
        end
    endtask

    task automatic test_random_mix(int unsigned count);
        for (int i = 0; i < count; i++) send_random_op(70);
    endtask

    task automatic test_backpressure();
        long_hold = 1'b1;
        for (int i = 0; i < 20; i++) send_random_op(50);
        long_hold = 1'b0;
    endtask

    task automatic test_full_rate(int unsigned count);
        quiet = 1'b1;
        for (int i = 0; i < count; i++) send_random_op(60);
    endtask

    always @(posedge aclk) begin
        int unsigned hold;
        if (long_hold) begin
            m_tready <= 1'b0;
            hold = 300;
            repeat (hold) @(posedge aclk);
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            m_tready <= 1'b0;
            hold = $urandom_range(1, 6);
            repeat (hold) @(posedge aclk);
        end
        m_tready <= 1'b1;
    end

    always @(posedge aclk) begin
        lookup_t got;
        lookup_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[24:0];
            if (pending_lookups.size() == 0) begin
                $error("Unexpected transaction: %h", m_tdata);
                error_count++;
            end else begin
                want = pending_lookups.pop_front();
                if (got.site_class !== want.site_class) begin
                    $error("site_class expected %0d got %0d", want.site_class,
                           got.site_class);
                    error_count++;
                end
                if (got.list_size !== want.list_size) begin
                    $error("list_size expected %0d got %0d", want.list_size, got.list_size);
                    error_count++;
                end
                if (got.entry_site !== want.entry_site) begin
                    $error("entry_site expected %0d got %0d", want.entry_site,
                           got.entry_site);
                    error_count++;
                end
                if (got.entry_valid !== want.entry_valid) begin
                    $error("entry_valid expected %0d got %0d", want.entry_valid,
                           got.entry_valid);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("ring_spin_class_list_engine_tb: FAIL");
            $finish;
        end
    end

    initial begin
        clear_ring();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_extremes();
        test_dense_cluster();
        test_random_mix(900);
        test_backpressure();
        test_full_rate(300);
        s_tvalid <= 1'b0;
        wait (pending_lookups.size() == 0);
        repeat (50) @(posedge aclk);
        if (error_count == 0) begin
            $display("ring_spin_class_list_engine_tb: PASS");
        end else begin
            $display("ring_spin_class_list_engine_tb: FAIL");
        end
        $finish;
    end
endmodule

/* files.f */
hdl/rscl_pkg.sv
hdl/rscl_ctrl.sv
hdl/rscl_datapath.sv
hdl/ring_spin_class_list_engine.sv
sim/ring_spin_class_list_engine_tb.sv
